// ===== rtl/core/scsa_pkg.sv =====
// ============================================================================
// scsa_pkg: shared definitions of the size class slab allocator
// Widths, bucket geometry, codes and the structs that pass between the
// sequencer, the shared multiply/divide unit and the free stack store.
// ============================================================================
package scsa_pkg;

   localparam int NUM_BUCKETS      = 4;
   localparam int MAX_ELEMS        = 1024;
   localparam int REGION_SPAN_LOG2 = 20;

   localparam int NB_REGS  = 4;
   localparam int NB_EFF   = (NUM_BUCKETS < NB_REGS) ? NUM_BUCKETS : NB_REGS;

   localparam int ADDR_W   = 32;
   localparam int SIZE_W   = 32;
   localparam int ELEM_W   = 16;
   localparam int REGION_W = 21;
   localparam int BKT_W    = 2;
   localparam int SLOT_W   = $clog2(MAX_ELEMS);
   localparam int COUNT_W  = $clog2(MAX_ELEMS + 1);
   localparam int ARITH_W  = (COUNT_W > REGION_W) ? COUNT_W : REGION_W;
   localparam int PROD_W   = ARITH_W + ELEM_W;
   localparam int STEP_W   = $clog2(ARITH_W);
   localparam int MEM_AW   = BKT_W + SLOT_W;
   localparam int MEM_DEPTH = NB_EFF << SLOT_W;

   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = REGION_W;
   localparam int CSR_ELEM_BASE   = 0;
   localparam int CSR_REGION_BASE = 4;

   localparam logic [ELEM_W-1:0] ELEM_RST [NB_REGS] =
      '{16'd16, 16'd64, 16'd256, 16'd1024};
   localparam logic [REGION_W-1:0] REGION_RST [NB_REGS] =
      '{21'd16384, 21'd65536, 21'd262144, 21'd1048576};

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_GRANTED  = 3'd0,
      ST_USE_SYS  = 3'd1,
      ST_FULL     = 3'd2,
      ST_FREED    = 3'd3,
      ST_SYS_FREE = 3'd4,
      ST_NULL     = 3'd5,
      ST_OVERFLOW = 3'd6
   } status_type;

   typedef enum logic {
      MD_MUL = 1'b0,
      MD_DIV = 1'b1
   } md_op_type;

   typedef struct packed {
      logic                start;
      md_op_type           op;
      logic [ARITH_W-1:0]  a;
      logic [ELEM_W-1:0]   b;
   } md_cmd_type;

   typedef struct packed {
      logic                done;
      logic [PROD_W-1:0]   result;
   } md_res_type;

   typedef enum logic [1:0] {
      STK_NONE = 2'd0,
      STK_POP  = 2'd1,
      STK_PUSH = 2'd2,
      STK_BUMP = 2'd3
   } stk_op_type;

   typedef struct packed {
      stk_op_type          op;
      logic [BKT_W-1:0]    bucket;
      logic [SLOT_W-1:0]   slot;
   } stk_cmd_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  count;
      logic [COUNT_W-1:0]  next_slot;
      logic [SLOT_W-1:0]   rd_slot;
   } stk_stat_type;

   function automatic logic [ADDR_W:0] bucket_base(input logic [BKT_W-1:0] bkt);
      bucket_base = ((ADDR_W+1)'(bkt) + (ADDR_W+1)'(1)) << REGION_SPAN_LOG2;
   endfunction

endpackage

// ===== rtl/core/scsa_if.sv =====
// ============================================================================
// scsa_if: request and response channels of the slab allocator
// Valid/ready channels; a beat moves when valid and ready are both high.
// ============================================================================
interface scsa_req_if;
   import scsa_pkg::*;

   logic                valid;
   logic                ready;
   cmd_type             cmd;
   logic [SIZE_W-1:0]   req_size;
   logic [ADDR_W-1:0]   free_addr;

   modport source (output valid, cmd, req_size, free_addr, input ready);
   modport sink   (input valid, cmd, req_size, free_addr, output ready);
endinterface

interface scsa_rsp_if;
   import scsa_pkg::*;

   logic                valid;
   logic                ready;
   logic [ADDR_W-1:0]   alloc_addr;
   logic [BKT_W-1:0]    bucket_used;
   status_type          status;

   modport source (output valid, alloc_addr, bucket_used, status, input ready);
   modport sink   (input valid, alloc_addr, bucket_used, status, output ready);
endinterface

// ===== rtl/core/size_class_slab_allocator.sv =====
// ============================================================================
// size_class_slab_allocator: size-class slab allocator, top level
// Sequencer, configuration registers, response register.
// ============================================================================
// One request is in work at a time; req_bus.ready is high only while the
// sequencer waits for a request, and a finished beat may sit in the response
// register while the next request is taken. An allocate that pops a freed
// slot steps through decode, alloc, pop wait, multiply and done; a bump of
// the next-slot counter through decode, alloc, multiply and done; a free into
// a bucket of nonzero element size through decode, free, divide and done.
// Answers that need no arithmetic (use system, system free, null, bucket full
// on a zero size or exhausted counter, overflow on a full stack) skip it. The
// shared bit-serial multiply/divide unit does it and retires one bit per
// cycle over ARITH_W steps. Configuration writes go through csr_we/csr_index/
// csr_wdata and must be issued only while no request is in work.
module size_class_slab_allocator (
   input  logic                              clock,
   input  logic                              reset,
   scsa_req_if.sink                          req_bus,
   scsa_rsp_if.source                        rsp_bus,
   input  logic                              csr_we,
   input  logic [scsa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [scsa_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import scsa_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_ALLOC,
      S_FREE,
      S_POP_WAIT,
      S_POP_MUL,
      S_BUMP_MUL,
      S_DIV,
      S_DONE
   } state_type;

   state_type           state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [BKT_W-1:0]    bucket_ff, bucket_in;
   logic [REGION_W-1:0] offset_ff, offset_in;
   logic [ADDR_W-1:0]   res_addr_ff, res_addr_in;
   status_type          res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [BKT_W-1:0]    rsp_bucket_ff, rsp_bucket_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [ELEM_W-1:0]   elem_ff   [NB_REGS];
   logic [ELEM_W-1:0]   elem_in   [NB_REGS];
   logic [REGION_W-1:0] region_ff [NB_REGS];
   logic [REGION_W-1:0] region_in [NB_REGS];

   md_cmd_type          md_cmd;
   md_res_type          md_res;
   stk_cmd_type         stk_cmd;
   stk_stat_type        stk_stat;

   logic                alloc_hit;
   logic [BKT_W-1:0]    alloc_bkt;
   logic                free_hit;
   logic [BKT_W-1:0]    free_bkt;
   logic [REGION_W-1:0] free_off;
   logic [ADDR_W:0]     free_diff;
   logic [ELEM_W-1:0]   sel_elem;
   logic [REGION_W-1:0] sel_region;
   logic [ADDR_W:0]     sel_base;
   logic [ADDR_W-1:0]   grant_addr;
   logic                bump_fits;
   logic                bump_full;
   logic                stack_full;
   logic                quot_big;
   logic                rsp_load;

   scsa_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_cmd (md_cmd),
      .md_res (md_res)
   );

   scsa_stack u_stack (
      .clock    (clock),
      .reset    (reset),
      .stk_cmd  (stk_cmd),
      .stk_stat (stk_stat)
   );

   always_comb begin
      alloc_hit = 1'b0;
      alloc_bkt = '0;
      free_hit  = 1'b0;
      free_bkt  = '0;
      free_off  = '0;
      free_diff = '0;
      for (int b = 0; b < NB_EFF; b++) begin
         if (!alloc_hit && (SIZE_W'(elem_ff[b]) >= size_ff)) begin
            alloc_hit = 1'b1;
            alloc_bkt = BKT_W'(b);
         end
         free_diff = {1'b0, addr_ff} - bucket_base(BKT_W'(b));
         if (!free_hit && !free_diff[ADDR_W] &&
             (free_diff < (ADDR_W+1)'(region_ff[b]))) begin
            free_hit = 1'b1;
            free_bkt = BKT_W'(b);
            free_off = free_diff[REGION_W-1:0];
         end
      end
   end

   assign sel_elem   = elem_ff[bucket_ff];
   assign sel_region = region_ff[bucket_ff];
   assign sel_base   = bucket_base(bucket_ff);
   assign grant_addr = sel_base[ADDR_W-1:0] + md_res.result[ADDR_W-1:0];
   assign bump_fits  = ((PROD_W+1)'(md_res.result) + (PROD_W+1)'(sel_elem))
                       <= (PROD_W+1)'(sel_region);
   assign bump_full  = (stk_stat.next_slot >= COUNT_W'(MAX_ELEMS)) ||
                       (sel_elem == '0);
   assign stack_full = stk_stat.count >= COUNT_W'(MAX_ELEMS);
   assign quot_big   = md_res.result >= PROD_W'(MAX_ELEMS);
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      size_in       = size_ff;
      addr_in       = addr_ff;
      bucket_in     = bucket_ff;
      offset_in     = offset_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      md_cmd.start  = 1'b0;
      md_cmd.op     = MD_MUL;
      md_cmd.a      = '0;
      md_cmd.b      = sel_elem;
      stk_cmd.op     = STK_NONE;
      stk_cmd.bucket = bucket_ff;
      stk_cmd.slot   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               cmd_in   = req_bus.cmd;
               size_in  = req_bus.req_size;
               addr_in  = req_bus.free_addr;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_addr_in = '0;
            if (cmd_ff == CMD_ALLOC) begin
               if (alloc_hit) begin
                  bucket_in = alloc_bkt;
                  state_in  = S_ALLOC;
               end else begin
                  bucket_in     = '0;
                  res_status_in = ST_USE_SYS;
                  state_in      = S_DONE;
               end
            end else if (addr_ff == '0) begin
               bucket_in     = '0;
               res_status_in = ST_NULL;
               state_in      = S_DONE;
            end else if (free_hit) begin
               bucket_in = free_bkt;
               offset_in = free_off;
               state_in  = S_FREE;
            end else begin
               bucket_in     = '0;
               res_status_in = ST_SYS_FREE;
               state_in      = S_DONE;
            end
         end
         S_ALLOC: begin
            if (stk_stat.count != '0) begin
               stk_cmd.op = STK_POP;
               state_in   = S_POP_WAIT;
            end else if (bump_full) begin
               res_status_in = ST_FULL;
               state_in      = S_DONE;
            end else begin
               md_cmd.start = 1'b1;
               md_cmd.op    = MD_MUL;
               md_cmd.a     = ARITH_W'(stk_stat.next_slot);
               state_in     = S_BUMP_MUL;
            end
         end
         S_POP_WAIT: begin
            md_cmd.start = 1'b1;
            md_cmd.op    = MD_MUL;
            md_cmd.a     = ARITH_W'(stk_stat.rd_slot);
            state_in     = S_POP_MUL;
         end
         S_POP_MUL: begin
            if (md_res.done) begin
               res_addr_in   = grant_addr;
               res_status_in = ST_GRANTED;
               state_in      = S_DONE;
            end
         end
         S_BUMP_MUL: begin
            if (md_res.done) begin
               if (bump_fits) begin
                  stk_cmd.op    = STK_BUMP;
                  res_addr_in   = grant_addr;
                  res_status_in = ST_GRANTED;
               end else begin
                  res_status_in = ST_FULL;
               end
               state_in = S_DONE;
            end
         end
         S_FREE: begin
            if (stack_full) begin
               res_status_in = ST_OVERFLOW;
               state_in      = S_DONE;
            end else if (sel_elem == '0) begin
               stk_cmd.op    = STK_PUSH;
               stk_cmd.slot  = '0;
               res_status_in = ST_FREED;
               state_in      = S_DONE;
            end else begin
               md_cmd.start = 1'b1;
               md_cmd.op    = MD_DIV;
               md_cmd.a     = ARITH_W'(offset_ff);
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            if (md_res.done) begin
               if (quot_big) begin
                  res_status_in = ST_OVERFLOW;
               end else begin
                  stk_cmd.op    = STK_PUSH;
                  stk_cmd.slot  = md_res.result[SLOT_W-1:0];
                  res_status_in = ST_FREED;
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_bucket_in = rsp_bucket_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_addr_in   = res_addr_ff;
         rsp_bucket_in = bucket_ff;
         rsp_status_in = res_status_ff;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      elem_in   = elem_ff;
      region_in = region_ff;
      for (int b = 0; b < NB_REGS; b++) begin
         if (csr_we && (csr_index == CSR_IDX_W'(CSR_ELEM_BASE + b))) begin
            elem_in[b] = csr_wdata[ELEM_W-1:0];
         end
         if (csr_we && (csr_index == CSR_IDX_W'(CSR_REGION_BASE + b))) begin
            region_in[b] = csr_wdata[REGION_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int b = 0; b < NB_REGS; b++) begin
            elem_ff[b]   <= ELEM_RST[b];
            region_ff[b] <= REGION_RST[b];
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         elem_ff      <= elem_in;
         region_ff    <= region_in;
      end
      cmd_ff        <= cmd_in;
      size_ff       <= size_in;
      addr_ff       <= addr_in;
      bucket_ff     <= bucket_in;
      offset_ff     <= offset_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_bucket_ff <= rsp_bucket_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_bus.ready       = (state_ff == S_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.alloc_addr  = rsp_addr_ff;
   assign rsp_bus.bucket_used = rsp_bucket_ff;
   assign rsp_bus.status      = rsp_status_ff;

   a_addr_only_on_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != ST_GRANTED) |-> rsp_addr_ff == '0)
      else $error("address returned without a grant");

   a_no_bucket_on_bypass: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == ST_USE_SYS || rsp_status_ff == ST_SYS_FREE ||
                       rsp_status_ff == ST_NULL) |-> rsp_bucket_ff == '0)
      else $error("bucket reported on a bypassed request");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      md_res.done |-> (state_ff == S_POP_MUL || state_ff == S_BUMP_MUL ||
                       state_ff == S_DIV))
      else $error("arithmetic result outside a wait state");

endmodule

// ===== rtl/core/scsa_muldiv.sv =====
// ============================================================================
// scsa_muldiv: bit-serial multiply / restoring divide unit
// One shared adder-subtractor, one operand bit per cycle, ARITH_W steps.
// ============================================================================
module scsa_muldiv (
   input  logic                 clock,
   input  logic                 reset,
   input  scsa_pkg::md_cmd_type md_cmd,
   output scsa_pkg::md_res_type md_res
);
   import scsa_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   md_op_type           op_ff, op_in;
   logic [ELEM_W-1:0]   b_ff, b_in;
   logic [ELEM_W-1:0]   hi_ff, hi_in;
   logic [ARITH_W-1:0]  lo_ff, lo_in;
   logic [STEP_W-1:0]   cnt_ff, cnt_in;

   logic                sub;
   logic [ELEM_W+1:0]   alu_x;
   logic [ELEM_W+1:0]   alu_y;
   logic [ELEM_W+1:0]   alu_sum;
   logic [ELEM_W:0]     mul_acc;

   assign sub     = (op_ff == MD_DIV);
   assign alu_x   = sub ? {1'b0, hi_ff, lo_ff[ARITH_W-1]} : {2'b00, hi_ff};
   assign alu_y   = {2'b00, b_ff} ^ {(ELEM_W+2){sub}};
   assign alu_sum = alu_x + alu_y + (ELEM_W+2)'(sub);
   assign mul_acc = lo_ff[0] ? alu_sum[ELEM_W:0] : {1'b0, hi_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      b_in    = b_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      cnt_in  = cnt_ff;
      if (md_cmd.start) begin
         busy_in = 1'b1;
         op_in   = md_cmd.op;
         b_in    = md_cmd.b;
         hi_in   = '0;
         lo_in   = md_cmd.a;
         cnt_in  = '0;
      end else if (busy_ff) begin
         if (op_ff == MD_MUL) begin
            hi_in = mul_acc[ELEM_W:1];
            lo_in = {mul_acc[0], lo_ff[ARITH_W-1:1]};
         end else if (!alu_sum[ELEM_W+1]) begin
            hi_in = alu_sum[ELEM_W-1:0];
            lo_in = {lo_ff[ARITH_W-2:0], 1'b1};
         end else begin
            hi_in = {hi_ff[ELEM_W-2:0], lo_ff[ARITH_W-1]};
            lo_in = {lo_ff[ARITH_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + STEP_W'(1);
         if (cnt_ff == STEP_W'(ARITH_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      b_ff   <= b_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      cnt_ff <= cnt_in;
   end

   assign md_res.done   = done_ff;
   assign md_res.result = (op_ff == MD_MUL) ? {hi_ff, lo_ff} : PROD_W'(lo_ff);

endmodule

// ===== rtl/core/scsa_stack.sv =====
// ============================================================================
// scsa_stack: per-bucket free stacks and bump counters
// One memory holds every bucket's LIFO of slot numbers; counters per bucket.
// ============================================================================
module scsa_stack (
   input  logic                   clock,
   input  logic                   reset,
   input  scsa_pkg::stk_cmd_type  stk_cmd,
   output scsa_pkg::stk_stat_type stk_stat
);
   import scsa_pkg::*;

   logic [COUNT_W-1:0] count_ff [NB_EFF];
   logic [COUNT_W-1:0] count_in [NB_EFF];
   logic [COUNT_W-1:0] next_ff  [NB_EFF];
   logic [COUNT_W-1:0] next_in  [NB_EFF];
   logic [SLOT_W-1:0]  rd_slot_ff;
   logic [SLOT_W-1:0]  mem [MEM_DEPTH];

   logic [COUNT_W-1:0] cur_count;
   logic [COUNT_W-1:0] cur_next;
   logic [COUNT_W-1:0] count_dec;
   logic [MEM_AW-1:0]  wr_addr;
   logic [MEM_AW-1:0]  rd_addr;

   assign cur_count = count_ff[stk_cmd.bucket];
   assign cur_next  = next_ff[stk_cmd.bucket];
   assign count_dec = cur_count - COUNT_W'(1);
   assign wr_addr   = {stk_cmd.bucket, cur_count[SLOT_W-1:0]};
   assign rd_addr   = {stk_cmd.bucket, count_dec[SLOT_W-1:0]};

   always_comb begin
      count_in = count_ff;
      next_in  = next_ff;
      unique case (stk_cmd.op)
         STK_POP:  count_in[stk_cmd.bucket] = count_dec;
         STK_PUSH: count_in[stk_cmd.bucket] = cur_count + COUNT_W'(1);
         STK_BUMP: next_in[stk_cmd.bucket]  = cur_next + COUNT_W'(1);
         STK_NONE: ;
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < NB_EFF; b++) begin
            count_ff[b] <= '0;
            next_ff[b]  <= '0;
         end
      end else begin
         count_ff <= count_in;
         next_ff  <= next_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stk_cmd.op == STK_PUSH) begin
         mem[wr_addr] <= stk_cmd.slot;
      end
      if (stk_cmd.op == STK_POP) begin
         rd_slot_ff <= mem[rd_addr];
      end
   end

   assign stk_stat.count     = cur_count;
   assign stk_stat.next_slot = cur_next;
   assign stk_stat.rd_slot   = rd_slot_ff;

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      stk_cmd.op == STK_PUSH |-> cur_count < COUNT_W'(MAX_ELEMS))
      else $error("push onto a full free stack");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      stk_cmd.op == STK_POP |-> cur_count != '0)
      else $error("pop from an empty free stack");

endmodule

// ===== sim/slab_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// slab_checker: response scoreboard of the size class slab allocator
// Watches the request, response and register ports, keeps its own copy of the
// bucket geometry, free stacks and bump counters, and compares every response
// beat, in order, with the answer worked out when its request was accepted.
// ============================================================================
module slab_checker (
   input  logic                            clock,
   input  logic                            reset,
   scsa_req_if                             req_mon,
   scsa_rsp_if                             rsp_mon,
   input  logic                            csr_we,
   input  logic [scsa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [scsa_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              fail_count,
   output int                              pending
);
   import scsa_pkg::*;

   localparam int SHOWN_MAX = 10;

   typedef struct packed {
      logic [ADDR_W-1:0] alloc_addr;
      logic [BKT_W-1:0]  bucket_used;
      status_type        status;
   } slab_answer_type;

   logic [ELEM_W-1:0]   elem_sz     [NB_REGS];
   logic [REGION_W-1:0] region_len  [NB_REGS];
   logic [SLOT_W-1:0]   free_slots  [NB_REGS][MAX_ELEMS];
   int unsigned         stack_depth [NB_REGS];
   int unsigned         bump_next   [NB_REGS];
   slab_answer_type     due_answers [$];

   function automatic slab_answer_type slab_serve(input cmd_type op,
                                                  input logic [SIZE_W-1:0] want,
                                                  input logic [ADDR_W-1:0] where);
      slab_answer_type ans;
      int unsigned     origin;
      int unsigned     cap;
      int unsigned     slot;
      int unsigned     off;
      ans = '{alloc_addr: '0, bucket_used: '0, status: ST_USE_SYS};
      if (op == CMD_ALLOC) begin
         for (int b = 0; b < NB_EFF; b++) begin
            if (elem_sz[b] >= want) begin
               origin = (b + 1) << REGION_SPAN_LOG2;
               cap = (elem_sz[b] == 0) ? 0 : region_len[b] / elem_sz[b];
               if (cap > MAX_ELEMS) cap = MAX_ELEMS;
               ans.bucket_used = BKT_W'(b);
               if (stack_depth[b] > 0) begin
                  stack_depth[b]--;
                  slot = free_slots[b][stack_depth[b]];
               end else if (bump_next[b] < cap) begin
                  slot = bump_next[b];
                  bump_next[b]++;
               end else begin
                  ans.status = ST_FULL;
                  return ans;
               end
               ans.alloc_addr = origin + slot * elem_sz[b];
               ans.status = ST_GRANTED;
               return ans;
            end
         end
         return ans;
      end
      if (where == '0) begin
         ans.status = ST_NULL;
         return ans;
      end
      for (int b = 0; b < NB_EFF; b++) begin
         origin = (b + 1) << REGION_SPAN_LOG2;
         if (where >= origin && where - origin < region_len[b]) begin
            off = where - origin;
            slot = (elem_sz[b] == 0) ? 0 : off / elem_sz[b];
            ans.bucket_used = BKT_W'(b);
            if (slot >= MAX_ELEMS || stack_depth[b] >= MAX_ELEMS) begin
               ans.status = ST_OVERFLOW;
            end else begin
               free_slots[b][stack_depth[b]] = SLOT_W'(slot);
               stack_depth[b]++;
               ans.status = ST_FREED;
            end
            return ans;
         end
      end
      ans.status = ST_SYS_FREE;
      return ans;
   endfunction

   always @(posedge clock) begin
      slab_answer_type due;
      if (reset) begin
         for (int b = 0; b < NB_REGS; b++) begin
            elem_sz[b]     = ELEM_RST[b];
            region_len[b]  = REGION_RST[b];
            stack_depth[b] = 0;
            bump_next[b]   = 0;
         end
         due_answers.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_answers.size() == 0) begin
               fail_count++;
               if (fail_count <= SHOWN_MAX)
                  $display("%0t: response beat with no request waiting: %s",
                           $realtime,
                           $sformatf("addr %h bucket %0d status %0d",
                                     rsp_mon.alloc_addr, rsp_mon.bucket_used,
                                     rsp_mon.status));
            end else begin
               due = due_answers.pop_front();
               if (rsp_mon.alloc_addr !== due.alloc_addr ||
                   rsp_mon.bucket_used !== due.bucket_used ||
                   rsp_mon.status !== due.status) begin
                  fail_count++;
                  if (fail_count <= SHOWN_MAX)
                     $display("%0t: mismatch (exp/got) addr %h/%h bucket %0d/%0d status %0d/%0d",
                              $realtime, due.alloc_addr, rsp_mon.alloc_addr,
                              due.bucket_used, rsp_mon.bucket_used,
                              due.status, rsp_mon.status);
               end
            end
         end
         if (csr_we) begin
            if (csr_index < CSR_REGION_BASE)
               elem_sz[csr_index - CSR_ELEM_BASE] = csr_wdata[ELEM_W-1:0];
            else
               region_len[csr_index - CSR_REGION_BASE] = csr_wdata[REGION_W-1:0];
         end
         if (req_mon.valid && req_mon.ready)
            due_answers = {due_answers, slab_serve(req_mon.cmd, req_mon.req_size,
                                                   req_mon.free_addr)};
      end
      pending = due_answers.size();
   end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top: testbench of the size class slab allocator
// Drives allocate and free requests in bursts, first a short directed list of
// corner cases, then random phases under several bucket geometries, plus one
// phase that floods one bucket with frees, some past its last slot. The
// response side stalls on its own pattern; the checker scores every beat.
// ============================================================================
module tb_top;
   import scsa_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 40;
   localparam int RANDOM_PHASES  = 9;
   localparam int PHASE_BEATS    = 33;
   localparam int FILL_BEATS     = 200;
   localparam int unsigned SPAN  = 1 << REGION_SPAN_LOG2;

   typedef enum {CFG_RESET, CFG_LADDER, CFG_WILD, CFG_EDGES, CFG_TIGHT} cfg_style_type;
   typedef enum {RX_OPEN, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    pending;
   int                    beats_sent;
   int                    burst_left;
   int                    idle_cycles;
   logic [ELEM_W-1:0]     cur_elem   [NB_REGS];
   logic [REGION_W-1:0]   cur_region [NB_REGS];
   logic [ADDR_W-1:0]     granted_pool [$];

   scsa_req_if req_bus ();
   scsa_rsp_if rsp_bus ();

   size_class_slab_allocator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   slab_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // keep granted addresses around so that later frees hit live slots
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready && rsp_bus.status == ST_GRANTED &&
          granted_pool.size() < 256)
         granted_pool = {granted_pool, rsp_bus.alloc_addr};
   end

   initial begin
      rx_mode_type mode;
      int          span;
      bit          held;
      held = 1'b0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (!held && beats_sent >= 80) begin
            held = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         mode = rx_mode_type'($urandom_range(0, 3));
         span = $urandom_range(5, 60);
         repeat (span) begin
            case (mode)
               RX_OPEN:   rsp_bus.ready <= 1'b1;
               RX_HALF:   rsp_bus.ready <= ($urandom_range(0, 1) == 1);
               RX_SPARSE: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default:   rsp_bus.ready <= ($urandom_range(0, 7) != 0);
            endcase
            @(posedge clock);
         end
      end
   end

   function automatic logic [ADDR_W-1:0] slab_origin(input int b);
      return ADDR_W'((b + 1) * SPAN);
   endfunction

   task automatic send_beat(input cmd_type op, input logic [SIZE_W-1:0] want,
                            input logic [ADDR_W-1:0] where);
      req_bus.valid     <= 1'b1;
      req_bus.cmd       <= op;
      req_bus.req_size  <= want;
      req_bus.free_addr <= where;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      beats_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 24)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 50)
                                                  : $urandom_range(0, 8);
      end
   endtask

   task automatic drain_all();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_regs();
      for (int i = 0; i < NB_REGS; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_IDX_W'(CSR_ELEM_BASE + i);
         csr_wdata <= CSR_DATA_W'(cur_elem[i]);
         @(posedge clock);
      end
      for (int i = 0; i < NB_REGS; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_IDX_W'(CSR_REGION_BASE + i);
         csr_wdata <= CSR_DATA_W'(cur_region[i]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic choose_config(input cfg_style_type style);
      for (int b = 0; b < NB_REGS; b++) begin
         case (style)
            CFG_RESET: begin
               cur_elem[b]   = ELEM_RST[b];
               cur_region[b] = REGION_RST[b];
            end
            CFG_LADDER: begin
               cur_elem[b]   = ELEM_W'($urandom_range(1, 48) << (3 * b));
               cur_region[b] = REGION_W'($urandom_range(0, SPAN));
            end
            CFG_WILD: begin
               cur_elem[b]   = ELEM_W'($urandom);
               cur_region[b] = REGION_W'($urandom);
            end
            CFG_EDGES: begin
               case ($urandom_range(0, 3))
                  0:       cur_elem[b] = 16'd1;
                  1:       cur_elem[b] = 16'hFFFF;
                  2:       cur_elem[b] = 16'd0;
                  default: cur_elem[b] = 16'd2;
               endcase
               case ($urandom_range(0, 3))
                  0:       cur_region[b] = 21'd0;
                  1:       cur_region[b] = 21'd1;
                  2:       cur_region[b] = 21'd1048576;
                  default: cur_region[b] = 21'h1FFFFF;
               endcase
            end
            default: begin
               cur_elem[b]   = ELEM_W'($urandom_range(1, 200) << (2 * b));
               cur_region[b] = REGION_W'(cur_elem[b] * $urandom_range(1, 6) +
                                         $urandom_range(0, 3));
            end
         endcase
      end
   endtask

   task automatic send_random();
      int                pick;
      int                b;
      int                idx;
      logic [SIZE_W-1:0] want;
      logic [ADDR_W-1:0] where;
      pick  = $urandom_range(0, 99);
      b     = $urandom_range(0, NB_EFF - 1);
      want  = $urandom;
      where = $urandom;
      if (pick < 38) begin
         case ($urandom_range(0, 3))
            0:       want = cur_elem[b];
            1:       want = cur_elem[b] + 1;
            2:       want = $urandom_range(0, 3);
            default: want = $urandom_range(0, cur_elem[b]);
         endcase
         send_beat(CMD_ALLOC, want, where);
      end else if (pick < 68 && granted_pool.size() > 0) begin
         idx   = $urandom_range(0, granted_pool.size() - 1);
         where = granted_pool[idx];
         granted_pool.delete(idx);
         send_beat(CMD_FREE, want, where);
      end else if (pick < 82) begin
         case ($urandom_range(0, 5))
            0:       where = slab_origin(b) - 1;
            1:       where = slab_origin(b) + cur_region[b];
            default: where = slab_origin(b) + $urandom_range(0, cur_region[b]);
         endcase
         send_beat(CMD_FREE, want, where);
      end else if (pick < 90) begin
         send_beat(CMD_ALLOC, want, where);
      end else if (pick < 96) begin
         send_beat(CMD_FREE, want, where);
      end else begin
         send_beat(CMD_FREE, want, '0);
      end
   endtask

   initial begin
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_index         <= '0;
      csr_wdata         <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.cmd       <= CMD_ALLOC;
      req_bus.req_size  <= '0;
      req_bus.free_addr <= '0;
      burst_left = 0;
      choose_config(CFG_RESET);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_beat(CMD_ALLOC, 32'd0, 32'd0);
      send_beat(CMD_ALLOC, 32'd16, 32'd0);
      send_beat(CMD_ALLOC, 32'd17, 32'd0);
      send_beat(CMD_ALLOC, 32'd1024, 32'd0);
      send_beat(CMD_ALLOC, 32'd1025, 32'd0);
      send_beat(CMD_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_beat(CMD_FREE, 32'd0, 32'd0);
      send_beat(CMD_FREE, 32'd0, 32'hFFFF_FFFF);
      send_beat(CMD_FREE, 32'd0, 32'h000F_FFFF);
      send_beat(CMD_FREE, 32'd0, 32'h0010_0000);
      send_beat(CMD_FREE, 32'd0, 32'h0010_0011);
      send_beat(CMD_ALLOC, 32'd16, 32'd0);
      send_beat(CMD_FREE, 32'd0, 32'h0010_4000);
      send_beat(CMD_FREE, 32'd0, 32'h004F_FFFF);
      send_beat(CMD_ALLOC, 32'd1000, 32'd0);
      send_beat(CMD_FREE, 32'd0, 32'h0020_0040);

      // zero element size, overlapping regions, pop after a size change
      drain_all();
      cur_elem   = '{16'd0, 16'd1, 16'hFFFF, 16'd300};
      cur_region = '{21'd100, 21'd1048576, 21'h1FFFFF, 21'd0};
      program_regs();
      send_beat(CMD_ALLOC, 32'd0, 32'd0);
      send_beat(CMD_ALLOC, 32'd0, 32'd0);
      send_beat(CMD_FREE, 32'd0, 32'h0010_0032);
      send_beat(CMD_ALLOC, 32'd0, 32'd0);
      send_beat(CMD_ALLOC, 32'd1, 32'd0);
      send_beat(CMD_FREE, 32'd0, 32'h0020_1388);
      send_beat(CMD_FREE, 32'd0, 32'h0040_000A);
      send_beat(CMD_ALLOC, 32'd65535, 32'd0);
      send_beat(CMD_ALLOC, 32'd65536, 32'd0);
      send_beat(CMD_FREE, 32'd0, 32'h005F_FFFF);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain_all();
         if (p == RANDOM_PHASES - 2) begin
            // flood bucket 0 with frees, some past its last slot
            choose_config(CFG_RESET);
            cur_elem[0]   = 16'd1;
            cur_region[0] = 21'd1048576;
            program_regs();
            repeat (FILL_BEATS)
               send_beat(CMD_FREE, $urandom, slab_origin(0) + $urandom_range(0, 1100));
            repeat (20) send_beat(CMD_ALLOC, $urandom_range(0, 1), $urandom);
            drain_all();
         end
         choose_config(cfg_style_type'(p % 5));
         program_regs();
         repeat (PHASE_BEATS) send_random();
      end

      drain_all();
      if (fail_count == 0 && pending == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/scsa_pkg.sv
rtl/core/scsa_if.sv
rtl/core/scsa_muldiv.sv
rtl/core/scsa_stack.sv
rtl/core/size_class_slab_allocator.sv
sim/slab_checker.sv
sim/tb_top.sv
